// ----- hw/rtl/dtsep_pkg.sv -----
// Shared types and constants for the grouped decimal text converter.
`default_nettype none
package dtsep_pkg;

    localparam int VALUE_W  = 64;
    localparam int DIGITS   = 20;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int CNT_W    = 7;
    localparam int IDX_W    = 5;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_SEPARATOR = '0;

    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] SEP_RESET  = 8'd44;

    localparam logic [IDX_W-1:0] TOP_DIGIT = IDX_W'(DIGITS - 1);
    localparam logic [1:0] TOP_GROUP = 2'((DIGITS - 1) % 3);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_DIGIT,
        S_SEP
    } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dtsep_dabble.sv -----
// Bit-serial binary to BCD converter using shift and add-three, one bit per cycle.
`default_nettype none
module dtsep_dabble
    import dtsep_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [VALUE_W-1:0] value_in,
    output logic                    done,
    output logic [BCD_W-1:0]        bcd
);

    logic [VALUE_W-1:0] bin_reg;
    logic [VALUE_W-1:0] bin_next;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               run_reg;
    logic               run_next;
    logic               done_reg;
    logic               done_next;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next = value_in;
            bcd_next = '0;
            cnt_next = CNT_W'(VALUE_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/decimal_with_thousands_separator_core.sv -----
// Top level: renders a 64-bit unsigned value as grouped decimal ASCII text.
//
// A request is taken on a rising edge with start high and busy low, and busy stays high
// until the last character of its text has been formed; that character is shown in the
// cycle in which busy falls. The value first passes through a bit-serial BCD
// converter, one bit per cycle. Leading zero digits (20 minus the digit count) are then
// dropped at one per cycle, and each character, digit or separator, is sent in its own
// cycle. Each character is shown on char_out and is_last for exactly one cycle with
// strobe high; the receiver cannot stall it and must take every strobe. The
// separator register is written through the APB port and should only be changed
// while busy is low.
`default_nettype none
module decimal_with_thousands_separator_core
    import dtsep_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [VALUE_W-1:0] value_in,
    output logic                    strobe,
    output logic [7:0]              char_out,
    output logic                    is_last,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    state_t             state_reg;
    state_t             state_next;
    logic [7:0]         sep_reg;
    logic [BCD_W-1:0]   dig_reg;
    logic [BCD_W-1:0]   dig_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [1:0]         grp_reg;
    logic [1:0]         grp_next;
    logic               strobe_reg;
    logic               strobe_next;
    logic [7:0]         char_reg;
    logic [7:0]         char_next;
    logic               last_reg;
    logic               last_next;
    logic               dab_start;
    logic               dab_done;
    logic [BCD_W-1:0]   dab_bcd;
    logic [3:0]         top_nib;
    logic               reg_hit;

    assign top_nib   = dig_reg[BCD_W-1 -: 4];
    assign dab_start = (state_reg == S_IDLE) && start;
    assign reg_hit   = (paddr[ADDR_W-1:2] == REG_SEPARATOR);

    dtsep_dabble u_dabble (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dab_start),
        .value_in (value_in),
        .done     (dab_done),
        .bcd      (dab_bcd)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (dab_done)
                begin
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                if (!((idx_reg != '0) && (top_nib == 4'd0)))
                begin
                    state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (idx_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (grp_reg == 2'd0)
                begin
                    state_next = S_SEP;
                end
            end
            S_SEP:
            begin
                state_next = S_DIGIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dig_next    = dig_reg;
        idx_next    = idx_reg;
        grp_next    = grp_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;
        case (state_reg)
            S_CONV:
            begin
                if (dab_done)
                begin
                    dig_next = dab_bcd;
                    idx_next = TOP_DIGIT;
                    grp_next = TOP_GROUP;
                end
            end
            S_SKIP:
            begin
                if ((idx_reg != '0) && (top_nib == 4'd0))
                begin
                    dig_next = {dig_reg[BCD_W-5:0], 4'd0};
                    idx_next = idx_reg - IDX_W'(1);
                    grp_next = (grp_reg == 2'd0) ? 2'd2 : grp_reg - 2'd1;
                end
            end
            S_DIGIT:
            begin
                strobe_next = 1'b1;
                char_next   = ASCII_ZERO + {4'd0, top_nib};
                last_next   = (idx_reg == '0);
                if (idx_reg != '0)
                begin
                    dig_next = {dig_reg[BCD_W-5:0], 4'd0};
                    idx_next = idx_reg - IDX_W'(1);
                    grp_next = (grp_reg == 2'd0) ? 2'd2 : grp_reg - 2'd1;
                end
            end
            S_SEP:
            begin
                strobe_next = 1'b1;
                char_next   = sep_reg;
                last_next   = 1'b0;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            sep_reg    <= SEP_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            if (psel && penable && pwrite && reg_hit)
            begin
                sep_reg <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        idx_reg  <= idx_next;
        grp_reg  <= grp_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign strobe   = strobe_reg;
    assign char_out = char_reg;
    assign is_last  = last_reg;
    assign pready   = 1'b1;
    assign prdata   = reg_hit ? {{(DATA_W - 8){1'b0}}, sep_reg} : '0;

`ifndef SYNTHESIS
    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_CONV))
        else $error("Accepted request did not start conversion.");

    a_last_ends_text: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && is_last) |=> !strobe)
        else $error("Character sent after the last one of a request.");

    a_busy_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !is_last) |-> busy)
        else $error("Block went idle before its text was complete.");

    a_no_strobe_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV) |-> !strobe)
        else $error("Character sent while conversion was running.");
`endif

endmodule
`default_nettype wire

// ----- dv/decimal_with_thousands_separator_core_test.sv -----
// Self-checking testbench for the grouped decimal text converter core.
module decimal_with_thousands_separator_core_test
    import dtsep_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GROUP_LEN = 3;
    localparam int MAX_CHARS = 26;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 120;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_IDX_W'(1);
    localparam logic [ADDR_W-1:0] SEP_ADDR = ADDR_W'({REG_SEPARATOR, 2'b00});
    localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'({REG_UNUSED, 2'b00});

    typedef struct {
        logic [7:0] ch;
        logic       last;
        int         request_id;
    } text_char_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [VALUE_W-1:0] value_in = '0;
    logic               strobe;
    logic [7:0]         char_out;
    logic               is_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    logic [VALUE_W-1:0] pending_values[$];
    text_char_t         expected_text[$];
    logic [7:0]         sep_model = SEP_RESET;
    logic [VALUE_W-1:0] ten_pow[DIGITS];
    bit                 steady_sender = 1'b0;
    int                 gap_left = 0;
    int                 requests_queued = 0;
    int                 requests_taken = 0;
    int                 chars_seen = 0;
    int                 sep_settings = 1;
    int                 idle_cycles = 0;
    int                 errors = 0;

    decimal_with_thousands_separator_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .value_in (value_in),
        .strobe   (strobe),
        .char_out (char_out),
        .is_last  (is_last),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void push_grouped_text(input logic [VALUE_W-1:0] value, input int id);
        logic [7:0]         rev[MAX_CHARS];
        int                 count;
        int                 digits;
        logic [VALUE_W-1:0] n;
        count = 0;
        digits = 0;
        n = value;
        do
        begin
            if (digits != 0 && digits % GROUP_LEN == 0)
            begin
                rev[count] = sep_model;
                count++;
            end
            rev[count] = ASCII_ZERO + 8'(n % 10);
            count++;
            n = n / 10;
            digits++;
        end
        while (n != 0);
        for (int k = count - 1; k >= 0; k--)
        begin
            expected_text.push_back('{ch: rev[k], last: (k == 0), request_id: id});
        end
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_sender || roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        int                 sel;
        v = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (sel < 7)
            v = v >> $urandom_range(0, 63);
        else if (sel == 7)
            v = ten_pow[$urandom_range(0, DIGITS - 1)] + $urandom_range(0, 2) - 1;
        return v;
    endfunction

    // Sender: holds a request until it is taken, then idles for a random gap.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                push_grouped_text(value_in, requests_taken);
                requests_taken <= requests_taken + 1;
            end
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_values.size() != 0)
            begin
                value_in <= pending_values.pop_front();
                start <= 1'b1;
                gap_left <= pick_gap();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            chars_seen <= chars_seen + 1;
            if (expected_text.size() == 0)
            begin
                report_mismatch($sformatf("unexpected char %02h last %0b", char_out, is_last));
            end
            else
            begin
                if (char_out !== expected_text[0].ch)
                    report_mismatch($sformatf("request %0d: char %02h, expected %02h",
                        expected_text[0].request_id, char_out, expected_text[0].ch));
                if (is_last !== expected_text[0].last)
                    report_mismatch($sformatf("request %0d: is_last %0b, expected %0b",
                        expected_text[0].request_id, is_last, expected_text[0].last));
                void'(expected_text.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog expired with %0d characters outstanding.",
                    expected_text.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr[ADDR_W-1:2] == REG_SEPARATOR)
        begin
            sep_model = data[7:0];
            sep_settings++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_check_read(input logic [ADDR_W-1:0] addr);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== DATA_W'(sep_model))
            report_mismatch($sformatf("separator read %08h, expected %02h", prdata, sep_model));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_value(input logic [VALUE_W-1:0] v);
        pending_values.push_back(v);
        requests_queued++;
    endtask

    task automatic wait_drained();
        while (pending_values.size() != 0 || requests_taken != requests_queued
               || expected_text.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        ten_pow[0] = 64'd1;
        for (int i = 1; i < DIGITS; i++)
            ten_pow[i] = ten_pow[i - 1] * 10;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        apb_check_read(SEP_ADDR);

        @(negedge clk);
        queue_value(64'd0);
        queue_value(64'd1);
        queue_value(64'd9);
        queue_value(64'd10);
        queue_value(64'd99);
        queue_value(64'd100);
        queue_value(64'd999);
        queue_value(64'd1000);
        queue_value(64'd999999);
        queue_value(64'd1000000);
        queue_value(64'd9999999999999999999);
        queue_value(64'd10000000000000000000);
        queue_value(64'd12345678901234567890);
        queue_value(64'h8000_0000_0000_0000);
        queue_value(64'h5555_5555_5555_5555);
        queue_value(64'hAAAA_AAAA_AAAA_AAAA);
        queue_value(64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();

        // A zero byte is a real separator, not an unset one.
        apb_write(SEP_ADDR, 32'd0);
        @(negedge clk);
        queue_value(64'd1000);
        queue_value(64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();

        apb_write(SEP_ADDR, 32'(ASCII_ZERO + 8'd5));
        @(negedge clk);
        queue_value(64'd5555555);
        queue_value(64'd123456);
        wait_drained();

        // The unused address must be ignored; only the low byte of a wide write is kept.
        apb_write(UNUSED_ADDR, 32'h0000_0041);
        apb_write(SEP_ADDR, 32'hFFFF_FF2E);
        apb_check_read(SEP_ADDR);
        @(negedge clk);
        queue_value(64'd4294967296);
        queue_value(64'd1234);
        wait_drained();

        apb_write(SEP_ADDR, 32'd255);
        @(negedge clk);
        queue_value(64'd18446744073709551615);
        queue_value(64'd100000);
        wait_drained();

        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase == 0)
                apb_write(SEP_ADDR, 32'(SEP_RESET));
            else
                apb_write(SEP_ADDR, $urandom);
            apb_check_read(SEP_ADDR);
            @(negedge clk);
            steady_sender = (phase == 2);
            for (int i = 0; i < 30; i++)
                queue_value(random_value());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Rendered %0d values into %0d characters under %0d separator settings.",
            requests_taken, chars_seen, sep_settings);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
